// ===== hw/rtl/lcs_pkg.sv =====
// Shared constants and types for the LFU store: sizes, the scan record and the update command.
package lcs_pkg;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned LimW       = 5;
  localparam int unsigned IdxW       = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned OccW       = $clog2(Capacity + 1);
  localparam int unsigned CmpW       = OccW + LimW;

  // Partial result handed from cell to cell during a scan.
  typedef struct packed {
    logic                  found;
    logic [IdxW-1:0]       found_idx;
    logic [IdxW-1:0]       found_rank;
    logic [DataW-1:0]      found_val;
    logic                  have_v;
    logic [IdxW-1:0]       v_idx;
    logic [CountWidth-1:0] v_cnt;
    logic [IdxW-1:0]       v_rank;
    logic [DataW-1:0]      v_key;
    logic                  have_free;
    logic [IdxW-1:0]       free_idx;
  } scan_t;

  localparam scan_t ScanInit = '0;

  // Update broadcast to every cell at the end of a request.
  typedef struct packed {
    logic             apply;
    logic             touch;
    logic             wr_val;
    logic             evict;
    logic             insert;
    logic [IdxW-1:0]  touch_idx;
    logic [IdxW-1:0]  touch_rank;
    logic [IdxW-1:0]  evict_idx;
    logic [IdxW-1:0]  evict_rank;
    logic [IdxW-1:0]  slot_idx;
    logic [DataW-1:0] key;
    logic [DataW-1:0] val;
  } cmd_t;

endpackage

// ===== hw/rtl/lcs_cell.sv =====
// One store entry: holds key, value, use count and recency rank, and joins the scan chain.
module lcs_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [lcs_pkg::IdxW-1:0]  idx_i,
  input  logic [lcs_pkg::DataW-1:0] key_i,
  input  lcs_pkg::scan_t         part_i,
  output lcs_pkg::scan_t         part_o,
  input  lcs_pkg::cmd_t          cmd_i
);
  import lcs_pkg::*;

  logic                  valid_q, valid_d;
  logic [DataW-1:0]      key_q, key_d;
  logic [DataW-1:0]      val_q, val_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]       rank_q, rank_d;
  scan_t                 part_q, part_d;
  logic                  better;

  assign part_o = part_q;

  always_comb begin
    part_d = part_i;
    if (!part_i.found && valid_q && key_q == key_i) begin
      part_d.found      = 1'b1;
      part_d.found_idx  = idx_i;
      part_d.found_rank = rank_q;
      part_d.found_val  = val_q;
    end
    better = !part_i.have_v || cnt_q < part_i.v_cnt ||
             (cnt_q == part_i.v_cnt && rank_q > part_i.v_rank);
    if (valid_q && better) begin
      part_d.have_v = 1'b1;
      part_d.v_idx  = idx_i;
      part_d.v_cnt  = cnt_q;
      part_d.v_rank = rank_q;
      part_d.v_key  = key_q;
    end
    if (!valid_q && !part_i.have_free) begin
      part_d.have_free = 1'b1;
      part_d.free_idx  = idx_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    rank_d  = rank_q;
    if (cmd_i.apply) begin
      if (cmd_i.touch) begin
        if (idx_i == cmd_i.touch_idx) begin
          rank_d = '0;
          if (cnt_q != {CountWidth{1'b1}}) begin
            cnt_d = cnt_q + CountWidth'(1);
          end
          if (cmd_i.wr_val) begin
            val_d = cmd_i.val;
          end
        end else if (valid_q && rank_q < cmd_i.touch_rank) begin
          rank_d = rank_q + IdxW'(1);
        end
      end
      if (cmd_i.evict && idx_i == cmd_i.evict_idx) begin
        valid_d = 1'b0;
      end else if (valid_q) begin
        if (cmd_i.evict && rank_q > cmd_i.evict_rank) begin
          rank_d = rank_d - IdxW'(1);
        end
        if (cmd_i.insert) begin
          rank_d = rank_d + IdxW'(1);
        end
      end
      if (cmd_i.insert && idx_i == cmd_i.slot_idx) begin
        valid_d = 1'b1;
        key_d   = cmd_i.key;
        val_d   = cmd_i.val;
        cnt_d   = CountWidth'(1);
        rank_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      part_q  <= ScanInit;
    end else begin
      valid_q <= valid_d;
      part_q  <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    rank_q <= rank_d;
  end

endmodule

// ===== hw/rtl/lfu_cache_store_core.sv =====
// Top level of the LFU key/value store: request control, cell chain and result register.
//
//   channel | signals                                         | direction
//   cfg     | cfg_we_i, cfg_wdata_i                            | in
//   in      | in_valid_i/in_ready_o, operation_i, key_i, write_value_i | in
//   out     | out_valid_o/out_ready_i, hit_o, read_value_o, evicted_o, evicted_key_o | out
//
// A request makes one pass of the scan record down the chain of cells, registered in each cell,
// and then applies the update in the update state.
// Reset clears every entry's valid bit and the occupancy at once; no clearing pass.
// The update waits while a previous result has not been taken; a new request is
// accepted while a finished result is still waiting.
module lfu_cache_store_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lcs_pkg::LimW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic signed [lcs_pkg::DataW-1:0] key_i,
  input  logic signed [lcs_pkg::DataW-1:0] write_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic signed [lcs_pkg::DataW-1:0] read_value_o,
  output logic                        evicted_o,
  output logic signed [lcs_pkg::DataW-1:0] evicted_key_o
);
  import lcs_pkg::*;

  typedef enum logic [1:0] {StIdle, StScan, StUpd} state_e;

  state_e           state_q;
  logic [IdxW-1:0]  step_q;
  logic [LimW-1:0]  lim_q;
  logic [OccW-1:0]  occ_q, occ_d;
  logic             op_q;
  logic [DataW-1:0] key_q, wval_q;
  logic             out_valid_q, hit_q, evicted_q;
  logic [DataW-1:0] read_value_q, evicted_key_q;

  scan_t            link [Capacity+1];
  scan_t            res;
  cmd_t             cmd;
  logic [CmpW-1:0]  lim_ext, lim_eff;
  logic             full, do_upd;
  logic [DataW-1:0] rd_val, ev_key;

  assign link[0] = ScanInit;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    lcs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IdxW'(i)),
      .key_i  (key_q),
      .part_i (link[i]),
      .part_o (link[i+1]),
      .cmd_i  (cmd)
    );
  end

  assign res     = link[Capacity];
  assign lim_ext = CmpW'(lim_q);
  assign lim_eff = (lim_ext > CmpW'(Capacity)) ? CmpW'(Capacity) : lim_ext;
  assign full    = CmpW'(occ_q) >= lim_eff;
  assign do_upd  = (state_q == StUpd) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd            = '0;
    cmd.apply      = do_upd;
    cmd.touch_idx  = res.found_idx;
    cmd.touch_rank = res.found_rank;
    cmd.evict_idx  = res.v_idx;
    cmd.evict_rank = res.v_rank;
    cmd.key        = key_q;
    cmd.val        = wval_q;
    cmd.slot_idx   = res.free_idx;
    occ_d          = occ_q;
    rd_val         = '0;
    ev_key         = '0;
    if (!op_q) begin
      if (res.found) begin
        cmd.touch = 1'b1;
        rd_val    = res.found_val;
      end
    end else if (lim_q != '0) begin
      if (res.found) begin
        cmd.touch  = 1'b1;
        cmd.wr_val = 1'b1;
      end else begin
        cmd.insert = 1'b1;
        if (full) begin
          cmd.evict = 1'b1;
          ev_key    = res.v_key;
          // The evicted entry is reused unless a lower free entry exists.
          if (!(res.have_free && res.free_idx < res.v_idx)) begin
            cmd.slot_idx = res.v_idx;
          end
        end else begin
          occ_d = occ_q + OccW'(1);
        end
      end
    end
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign read_value_o  = read_value_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      lim_q       <= LimW'(16);
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StScan;
            step_q  <= '0;
          end
        end
        StScan: begin
          if (step_q == IdxW'(Capacity - 1)) begin
            state_q <= StUpd;
          end else begin
            step_q <= step_q + IdxW'(1);
          end
        end
        StUpd: begin
          if (do_upd) begin
            state_q     <= StIdle;
            occ_q       <= occ_d;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= operation_i;
      key_q  <= key_i;
      wval_q <= write_value_i;
    end
    if (do_upd) begin
      hit_q         <= res.found;
      read_value_q  <= rd_val;
      evicted_q     <= cmd.evict;
      evicted_key_q <= ev_key;
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(Capacity))
    else $error("occupancy exceeds capacity");
  a_out_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StUpd))
    else $error("result raised outside the update step");
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StScan && step_q == '0))
    else $error("accepted request did not start a scan");
  a_evict_has_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_upd && cmd.evict) |-> res.have_v)
    else $error("eviction without a victim");
`endif

endmodule
